// ----- design/circular_list_engine_defines.svh -----
// Assertion macros for the circular list engine checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef CIRCULAR_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cle_pkg.sv -----
// Shared types and constants for the circular list engine.
// No dependencies; used by the top level and its checker.
package cle_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_DHEAD,
    S_DWALK,
    S_SHOW,
    S_WR1,
    S_WR2,
    S_DONE
  } state_t;

endpackage

// ----- design/circular_list_engine.sv -----
// Circular linked list held in a value memory and a link memory.
// Depends on cle_pkg for command, status and state codes.
//
// Usage:
//   Input requests arrive on in_tvalid/in_tready: in_tuser carries the
//   command (insert, delete by value, display), in_tdata the value.
//   Results leave on out_tvalid/out_tready: out_tuser carries the status,
//   out_tdata the listed value (zero except on display), out_tlast marks
//   the final result of a request. Command code 3 is taken and dropped.
// Request flow:
//   One request is worked on at a time; in_tready is high only when idle.
//   Every step along the list is one read of the link memory, so the
//   length of the list sets how long a request takes.
//   The output register lets a new request be taken while the last result
//   still waits.
// Reset and stall:
//   Reset empties the list and rewinds the allocator; memories are not
//   cleared. A stalled receiver holds the output register and pauses the
//   display walk; nothing is dropped.
module circular_list_engine
  import cle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [VALUE_W-1:0]  in_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]    in_tuser,   // [1:0] cmd
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VALUE_W-1:0]  out_tdata,  // [31:0] item_value
  output logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic                out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Node store
  logic [VALUE_W-1:0] value_mem [CAPACITY];
  logic [IDX_W-1:0]   link_mem  [CAPACITY];
  logic [VALUE_W-1:0] val_q;
  logic [IDX_W-1:0]   link_q;

  logic               vwr_en;
  logic [IDX_W-1:0]   vwr_addr;
  logic [VALUE_W-1:0] vwr_data;
  logic               lwr_en;
  logic [IDX_W-1:0]   lwr_addr;
  logic [IDX_W-1:0]   lwr_data;

  // Control and list state
  state_t             state_r, state_nxt;
  cmd_t               op_r, op_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   prev_r, prev_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  status_t            st_r, st_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]   alloc_r, alloc_nxt;

  // Output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [VALUE_W-1:0] out_item_r;
  logic               out_last_r;

  logic               emit;
  status_t            emit_status;
  logic [VALUE_W-1:0] emit_item;
  logic               emit_last;

  cmd_t               in_cmd;
  logic               in_acc;
  logic               out_free;
  logic               head_eq;
  logic               hit;
  logic               alloc_full;
  logic               tail_more;
  logic               walk_more;
  logic               show_last;
  logic [IDX_W-1:0]   new_idx;

  assign in_cmd     = cmd_t'(in_tuser);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign head_eq    = (link_q == head_r);
  assign hit        = (val_q == val_r);
  assign alloc_full = (alloc_r >= CNT_W'(CAPACITY));
  assign tail_more  = !head_eq && (steps_r < CNT_W'(CAPACITY));
  assign walk_more  = !head_eq && (steps_r < CNT_W'(CAPACITY - 1));
  assign show_last  = head_eq || (steps_r >= CNT_W'(CAPACITY - 1));
  assign new_idx    = alloc_r[IDX_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_cmd)
            CMD_INSERT: begin
              if (alloc_full) state_nxt = S_DONE;
              else if (!nonempty_r) state_nxt = S_WR1;
              else state_nxt = S_TAIL;
            end
            CMD_DELETE:  state_nxt = nonempty_r ? S_DHEAD : S_DONE;
            CMD_DISPLAY: state_nxt = nonempty_r ? S_SHOW : S_DONE;
            CMD_NONE:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_TAIL:  state_nxt = tail_more ? S_TAIL : S_WR1;
      S_DHEAD: begin
        if (hit) state_nxt = head_eq ? S_DONE : S_TAIL;
        else state_nxt = head_eq ? S_DONE : S_DWALK;
      end
      S_DWALK: state_nxt = (!hit && walk_more) ? S_DWALK : S_DONE;
      S_SHOW:  state_nxt = (out_free && show_last) ? S_IDLE : S_SHOW;
      S_WR1:   state_nxt = (op_r == CMD_INSERT && nonempty_r) ? S_WR2 : S_DONE;
      S_WR2:   state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
    endcase
  end

  // Datapath, memory writes and result emission
  always_comb begin
    op_nxt       = op_r;
    val_nxt      = val_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    steps_nxt    = steps_r;
    st_nxt       = st_r;
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    alloc_nxt    = alloc_r;
    vwr_en       = 1'b0;
    vwr_addr     = new_idx;
    vwr_data     = val_r;
    lwr_en       = 1'b0;
    lwr_addr     = cur_r;
    lwr_data     = new_idx;
    emit         = 1'b0;
    emit_status  = st_r;
    emit_item    = '0;
    emit_last    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_cmd;
          val_nxt   = in_tdata;
          cur_nxt   = head_r;
          steps_nxt = '0;
          st_nxt    = ST_OK;
          if (in_cmd == CMD_INSERT && alloc_full) st_nxt = ST_FULL;
          if (in_cmd != CMD_INSERT && !nonempty_r) st_nxt = ST_EMPTY;
        end
      end
      S_TAIL: begin
        // advance until the node whose link returns to the head
        if (tail_more) begin
          cur_nxt   = link_q;
          steps_nxt = steps_r + CNT_W'(1);
        end
      end
      S_DHEAD: begin
        if (hit) begin
          if (head_eq) begin
            nonempty_nxt = 1'b0;
          end else begin
            prev_nxt  = link_q;
            cur_nxt   = head_r;
            steps_nxt = '0;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_q;
          steps_nxt = '0;
          if (head_eq) st_nxt = ST_NOTFOUND;
        end
      end
      S_DWALK: begin
        if (hit) begin
          // unlink the matching node
          lwr_en   = 1'b1;
          lwr_addr = prev_r;
          lwr_data = link_q;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_q;
          steps_nxt = steps_r + CNT_W'(1);
          if (!walk_more) st_nxt = ST_NOTFOUND;
        end
      end
      S_SHOW: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_item   = val_q;
          emit_last   = show_last;
          if (!show_last) begin
            cur_nxt   = link_q;
            steps_nxt = steps_r + CNT_W'(1);
          end
        end
      end
      S_WR1: begin
        if (op_r == CMD_INSERT) begin
          vwr_en = 1'b1;
          lwr_en = 1'b1;
          if (nonempty_r) begin
            // tail points to the new node
            lwr_addr = cur_r;
            lwr_data = new_idx;
          end else begin
            // first node links to itself
            lwr_addr     = new_idx;
            lwr_data     = new_idx;
            head_nxt     = new_idx;
            nonempty_nxt = 1'b1;
            alloc_nxt    = alloc_r + CNT_W'(1);
          end
        end else begin
          // drop the old head: tail points to the new head
          lwr_en   = 1'b1;
          lwr_addr = cur_r;
          lwr_data = prev_r;
          head_nxt = prev_r;
        end
      end
      S_WR2: begin
        lwr_en    = 1'b1;
        lwr_addr  = new_idx;
        lwr_data  = head_r;
        alloc_nxt = alloc_r + CNT_W'(1);
      end
      S_DONE: begin
        emit = out_free;
      end
    endcase
  end

  // Memories: read at the next node index, data valid for cur_r
  always_ff @(posedge clk) begin
    if (vwr_en) value_mem[vwr_addr] <= vwr_data;
    val_q <= value_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (lwr_en) link_mem[lwr_addr] <= lwr_data;
    link_q <= link_mem[cur_nxt];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      nonempty_r  <= 1'b0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      alloc_r    <= alloc_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    st_r    <= st_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_item_r   <= emit_item;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/cle_checker.sv -----
// Port-level checks for the circular list engine, bound to the top level.
// Depends on cle_pkg and circular_list_engine_defines.svh.
`include "circular_list_engine_defines.svh"

module cle_checker
  import cle_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [CMD_W-1:0]    in_tuser,   // [1:0] cmd
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [VALUE_W-1:0]  out_tdata,  // [31:0] item_value
  input logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  input logic                out_tlast
);

  // hold a stalled result
  `CLE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // an error status ends the request's results
  `CLE_ASSERT_IMP(a_err_last, out_tvalid && out_tuser != ST_OK, out_tlast, "error result without last")

  // results with an error status carry a zero value
  `CLE_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata == '0, "error result with nonzero value")

  // a real command keeps the input closed while it is worked on
  `CLE_ASSERT_NXT(a_busy, in_tvalid && in_tready && in_tuser != CMD_NONE, !in_tready, "input open during a request")

endmodule

bind circular_list_engine cle_checker u_cle_checker (.*);

// ----- verif/circular_list_engine_test.sv -----
// Self-checking testbench for circular_list_engine: insert, delete and display requests.
// Predicts every result from its own list model; needs cle_pkg and the engine RTL only.
module circular_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int IDX_W        = $clog2(CAP);
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int CHURN_ITEMS  = 150;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] item_value;
    logic               last;
  } list_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata;
  logic [CMD_W-1:0]    in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [VALUE_W-1:0]  out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                out_tlast;

  // Shadow list: node values, next links, head, nonempty flag, bump allocator
  bit [VALUE_W-1:0] node_value [CAP];
  bit [IDX_W-1:0]   node_next  [CAP];
  bit [IDX_W-1:0]   head_slot;
  bit               list_live;
  bit [IDX_W:0]     next_free;

  list_result_t pending_results[$];
  int           error_count;
  int           stall_cycles;
  bit           quiet_run;

  circular_list_engine #(.CAPACITY(CAP)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- list model

  // Walk to the node whose link closes the circle, bounded by capacity
  function automatic bit [IDX_W-1:0] tail_slot();
    bit [IDX_W-1:0] t;
    int             steps;
    t = head_slot;
    steps = 0;
    while (node_next[t] != head_slot && steps < CAP) begin
      t = node_next[t];
      steps++;
    end
    return t;
  endfunction

  function automatic status_t insert_node(bit [VALUE_W-1:0] v);
    bit [IDX_W-1:0] n;
    bit [IDX_W-1:0] t;
    if (next_free >= CAP) return ST_FULL;
    n = next_free[IDX_W-1:0];
    node_value[n] = v;
    if (!list_live) begin
      head_slot = n;
      node_next[n] = n;
      list_live = 1'b1;
    end else begin
      t = tail_slot();
      node_next[t] = n;
      node_next[n] = head_slot;
    end
    next_free++;
    return ST_OK;
  endfunction

  function automatic status_t delete_node(bit [VALUE_W-1:0] v);
    bit [IDX_W-1:0] h;
    bit [IDX_W-1:0] prev;
    bit [IDX_W-1:0] cur;
    bit [IDX_W-1:0] t;
    int             steps;
    if (!list_live) return ST_EMPTY;
    h = head_slot;
    // Head match: empty the list or move the head and close the circle again
    if (node_value[h] == v) begin
      if (node_next[h] == h) begin
        list_live = 1'b0;
      end else begin
        t = tail_slot();
        head_slot = node_next[h];
        node_next[t] = head_slot;
      end
      return ST_OK;
    end
    prev = h;
    cur = node_next[h];
    steps = 0;
    while (cur != h && steps < CAP) begin
      if (node_value[cur] == v) begin
        node_next[prev] = node_next[cur];
        return ST_OK;
      end
      prev = cur;
      cur = node_next[cur];
      steps++;
    end
    return ST_NOTFOUND;
  endfunction

  function automatic void display_list();
    bit [IDX_W-1:0] cur;
    bit [IDX_W-1:0] nx;
    int             k;
    bit             done;
    if (!list_live) begin
      pending_results.push_back('{status: ST_EMPTY, item_value: '0, last: 1'b1});
      return;
    end
    cur = head_slot;
    k = 0;
    done = 1'b0;
    while (!done) begin
      nx = node_next[cur];
      done = (nx == head_slot) || (k + 1 >= CAP);
      pending_results.push_back('{status: ST_OK, item_value: node_value[cur], last: done});
      k++;
      cur = nx;
    end
  endfunction

  function automatic void predict_request(cmd_t c, bit [VALUE_W-1:0] v);
    case (c)
      CMD_INSERT:
        pending_results.push_back('{status: insert_node(v), item_value: '0, last: 1'b1});
      CMD_DELETE:
        pending_results.push_back('{status: delete_node(v), item_value: '0, last: 1'b1});
      CMD_DISPLAY:
        display_list();
      default: ;  // unused code: dropped, no result
    endcase
  endfunction

  // Pick a value currently held in the list, at a random position
  function automatic bit [VALUE_W-1:0] live_value();
    bit [IDX_W-1:0] t;
    int             len;
    int             k;
    t = head_slot;
    len = 1;
    while (node_next[t] != head_slot && len < CAP) begin
      t = node_next[t];
      len++;
    end
    k = $urandom_range(len - 1);
    t = head_slot;
    repeat (k) t = node_next[t];
    return node_value[t];
  endfunction

  // Mix of wide random values, a small pool for duplicates, extremes and copies
  function automatic bit [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom;
    if (r < 75) return $urandom_range(7);
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (list_live) return live_value();
    return $urandom;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one request; hold valid across back-to-back requests
  task automatic send_request(cmd_t c, bit [VALUE_W-1:0] v);
    if (!quiet_run) begin
      while ($urandom_range(99) < 10) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(c, v);
  endtask

  // Stall the result side at random, except during quiet stretches
  always @(posedge clk) begin
    out_tready <= quiet_run ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // ---------------------------------------------------------------- checking

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%h last=%b",
                                  out_tuser, out_tdata, out_tlast));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        if (out_tdata !== want.item_value)
          report_mismatch($sformatf("item_value %h, want %h", out_tdata, want.item_value));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
      end
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("circular_list_engine_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // Display and delete on a fresh list, and the unused code
  task automatic test_empty_list();
    send_request(CMD_DISPLAY, 32'h0000_0000);
    send_request(CMD_DELETE, 32'h0000_0000);
    send_request(CMD_NONE, 32'hffff_ffff);
  endtask

  // Insert field extremes, the constants and a duplicate
  task automatic test_extreme_inserts();
    send_request(CMD_INSERT, 32'h7fff_ffff);
    send_request(CMD_INSERT, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h0000_0000);
    send_request(CMD_INSERT, 32'hffff_ffff);
    send_request(CMD_INSERT, 32'd25);
    send_request(CMD_INSERT, 32'd25);
    send_request(CMD_DISPLAY, 32'h5555_aaaa);
  endtask

  // Grow the list until the allocator runs out, no deletions that hit
  task automatic test_random_grow();
    int r;
    while (next_free < CAP) begin
      r = $urandom_range(99);
      if (r < 70)      send_request(CMD_INSERT, pick_value());
      else if (r < 82) send_request(CMD_DISPLAY, $urandom);
      else if (r < 94) send_request(CMD_DELETE, $urandom);
      else             send_request(CMD_NONE, $urandom);
    end
  endtask

  // Insert into a full store, then list all nodes
  task automatic test_full_insert();
    quiet_run = 1'b1;
    send_request(CMD_INSERT, 32'h0000_0001);
    send_request(CMD_DISPLAY, 32'haaaa_5555);
  endtask

  // Delete head, first of duplicates, absent value, tail and middle
  task automatic test_delete_cases();
    send_request(CMD_DELETE, 32'h7fff_ffff);
    send_request(CMD_DELETE, 32'd25);
    send_request(CMD_DELETE, 32'h1234_5678);
    send_request(CMD_DELETE, node_value[tail_slot()]);
    send_request(CMD_DELETE, 32'hffff_ffff);
    send_request(CMD_DISPLAY, 32'h0000_0000);
    quiet_run = 1'b0;
  endtask

  // Shrink the list to nothing with mixed requests; inserts now report full
  task automatic test_random_churn();
    int n;
    int r;
    n = 0;
    while (n < CHURN_ITEMS || list_live) begin
      quiet_run = (n >= 20 && n < 60);
      r = $urandom_range(99);
      if (r < 25)      send_request(CMD_DELETE, list_live ? live_value() : $urandom);
      else if (r < 35) send_request(CMD_DELETE, pick_value());
      else if (r < 60) send_request(CMD_DISPLAY, $urandom);
      else if (r < 80) send_request(CMD_INSERT, pick_value());
      else if (r < 90) send_request(CMD_NONE, $urandom);
      else             send_request(CMD_DELETE, $urandom);
      n++;
    end
    quiet_run = 1'b0;
  endtask

  // After draining, the allocator stays exhausted
  task automatic test_drained_list();
    send_request(CMD_DISPLAY, 32'hffff_ffff);
    send_request(CMD_DELETE, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h0000_0000);
  endtask

  // Drop valid and wait for every expected result, then a margin
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    error_count  = 0;
    stall_cycles = 0;
    quiet_run    = 1'b0;
    head_slot    = '0;
    list_live    = 1'b0;
    next_free    = '0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= CMD_INSERT;
    out_tready   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_extreme_inserts();
    test_random_grow();
    test_full_insert();
    test_delete_cases();
    test_random_churn();
    test_drained_list();
    drain_results();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("circular_list_engine_test: done, clean");
    end else begin
      $display("circular_list_engine_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/cle_pkg.sv
design/circular_list_engine.sv
design/cle_checker.sv
verif/circular_list_engine_test.sv
